// ----- rtl/fvsd_pkg.sv -----
// shared widths, constants and stage records for the voltage to duty pipeline
package fvsd_pkg;

    localparam int VOLT_W    = 16;
    localparam int TRIG_W    = 16;
    localparam int BUS_W     = 16;
    localparam int DUTY_W    = 16;
    localparam int DUTY_FRAC = 15;
    localparam int GUARD     = 4;
    localparam int ROT_SHIFT = TRIG_W - 1 - GUARD;
    localparam int PROD_RAW_W = VOLT_W + TRIG_W;
    localparam int AB_W      = 21;
    localparam int M2_W      = 2 * AB_W;
    localparam int LIM_W     = 2 * BUS_W + 2 * GUARD;
    localparam int ROOT_W    = 21;
    localparam int ROOT_SQ_W = 2 * ROOT_W + 3;
    localparam int PROD_W    = AB_W + ROOT_W;
    localparam int K3_W      = 17;
    localparam logic [K3_W-1:0] HALF_SQRT3 = 17'd56756;
    localparam int S3_SHIFT  = 15;
    localparam int W_W       = 24;
    localparam int U_W       = 26;
    localparam int QD_W      = 17;
    localparam int NUM_SHIFT = 10;
    localparam int NUM_W     = U_W + NUM_SHIFT + 1;
    localparam logic [DUTY_W-1:0] HALF_DUTY = DUTY_W'(1) << (DUTY_FRAC - 1);
    localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(1) << DUTY_FRAC;

    // alpha/beta with magnitudes squared, leaving the front end
    typedef struct packed {
        logic              fault;
        logic              limited;
        logic              neg_a;
        logic              neg_b;
        logic [AB_W-1:0]   abs_a;
        logic [AB_W-1:0]   abs_b;
        logic [BUS_W-1:0]  bus;
        logic [M2_W-1:0]   m2;
        logic [LIM_W-1:0]  lim2;
    } sq_t;

    // square root progress for magnitude and limit radius
    typedef struct packed {
        sq_t                  base;
        logic [ROOT_W-1:0]    mag;
        logic [ROOT_SQ_W-1:0] mag_sq;
        logic [ROOT_W-1:0]    vmax;
        logic [ROOT_SQ_W-1:0] vmax_sq3;
    } rt_t;

    // centred phase voltages at four times the guard grid
    typedef struct packed {
        logic                 fault;
        logic                 limited;
        logic [BUS_W-1:0]     bus;
        logic signed [U_W-1:0] u_a;
        logic signed [U_W-1:0] u_b;
        logic signed [U_W-1:0] u_c;
    } ph_t;

endpackage

// ----- rtl/fvsd_front.sv -----
// inverse park rotation, magnitude squares and limit test
module fvsd_front
    import fvsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VOLT_W-1:0] volt_d,
    input  logic signed [VOLT_W-1:0] volt_q,
    input  logic signed [TRIG_W-1:0] angle_sine,
    input  logic signed [TRIG_W-1:0] angle_cosine,
    input  logic [BUS_W-1:0]         bus_voltage,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sq_t                      out_data
);

    localparam int NS = 4;

    typedef struct packed {
        logic                         fault;
        logic [BUS_W-1:0]             bus;
        logic signed [PROD_RAW_W-1:0] p_dc;
        logic signed [PROD_RAW_W-1:0] p_qs;
        logic signed [PROD_RAW_W-1:0] p_ds;
        logic signed [PROD_RAW_W-1:0] p_qc;
    } f0_t;

    typedef struct packed {
        logic             fault;
        logic [BUS_W-1:0] bus;
        logic             neg_a;
        logic             neg_b;
        logic [AB_W-1:0]  abs_a;
        logic [AB_W-1:0]  abs_b;
    } f1_t;

    logic [NS-1:0] v_reg, v_next, v_src;
    logic [NS:0]   rdy;

    f0_t s0_reg, s0_next;
    f1_t s1_reg, s1_next;
    sq_t s2_reg, s2_next;
    sq_t s3_reg, s3_next;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int j = NS - 1; j >= 0; j--)
        begin
            rdy[j] = !v_reg[j] || rdy[j+1];
        end
    end

    assign v_src  = {v_reg[NS-2:0], in_valid};
    assign v_next = (v_src & rdy[NS-1:0]) | (v_reg & ~rdy[NS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // products of command and angle
    always_comb
    begin
        s0_next.fault = (bus_voltage == '0);
        s0_next.bus   = bus_voltage;
        s0_next.p_dc  = PROD_RAW_W'(volt_d * angle_cosine);
        s0_next.p_qs  = PROD_RAW_W'(volt_q * angle_sine);
        s0_next.p_ds  = PROD_RAW_W'(volt_d * angle_sine);
        s0_next.p_qc  = PROD_RAW_W'(volt_q * angle_cosine);
    end

    // sums rounded half away from zero onto the guard grid
    always_comb
    begin
        logic signed [PROD_RAW_W:0] sa, sb;
        logic [PROD_RAW_W:0]        ma, mb;
        sa = (PROD_RAW_W+1)'(s0_reg.p_dc) - (PROD_RAW_W+1)'(s0_reg.p_qs);
        sb = (PROD_RAW_W+1)'(s0_reg.p_ds) + (PROD_RAW_W+1)'(s0_reg.p_qc);
        ma = sa[PROD_RAW_W] ? -sa : sa;
        mb = sb[PROD_RAW_W] ? -sb : sb;
        ma = ma + ((PROD_RAW_W+1)'(1) << (ROT_SHIFT - 1));
        mb = mb + ((PROD_RAW_W+1)'(1) << (ROT_SHIFT - 1));
        s1_next.fault = s0_reg.fault;
        s1_next.bus   = s0_reg.bus;
        s1_next.neg_a = sa[PROD_RAW_W];
        s1_next.neg_b = sb[PROD_RAW_W];
        s1_next.abs_a = ma[ROT_SHIFT +: AB_W];
        s1_next.abs_b = mb[ROT_SHIFT +: AB_W];
    end

    always_comb
    begin
        logic [M2_W-1:0] sq_a, sq_b;
        logic [2*BUS_W-1:0] bus_sq;
        sq_a   = M2_W'(s1_reg.abs_a) * M2_W'(s1_reg.abs_a);
        sq_b   = M2_W'(s1_reg.abs_b) * M2_W'(s1_reg.abs_b);
        bus_sq = (2*BUS_W)'(s1_reg.bus) * (2*BUS_W)'(s1_reg.bus);
        s2_next.fault   = s1_reg.fault;
        s2_next.limited = 1'b0;
        s2_next.neg_a   = s1_reg.neg_a;
        s2_next.neg_b   = s1_reg.neg_b;
        s2_next.abs_a   = s1_reg.abs_a;
        s2_next.abs_b   = s1_reg.abs_b;
        s2_next.bus     = s1_reg.bus;
        s2_next.m2      = sq_a + sq_b;
        s2_next.lim2    = LIM_W'(bus_sq) << (2 * GUARD);
    end

    // exact test 3*m2 > bus^2 on the guard grid
    always_comb
    begin
        logic [M2_W+1:0] m2x3;
        m2x3 = ((M2_W+2)'(s2_reg.m2) << 1) + (M2_W+2)'(s2_reg.m2);
        s3_next         = s2_reg;
        s3_next.limited = !s2_reg.fault && (m2x3 > (M2_W+2)'(s2_reg.lim2));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) s0_reg <= s0_next;
        if (rdy[1]) s1_reg <= s1_next;
        if (rdy[2]) s2_reg <= s2_next;
        if (rdy[3]) s3_reg <= s3_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s3_reg;

endmodule

// ----- rtl/fvsd_sqrt.sv -----
// bit per stage integer square roots of the vector magnitude and the limit radius
module fvsd_sqrt
    import fvsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sq_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output rt_t  out_data
);

    localparam int NS = ROOT_W;

    function automatic rt_t root_step(rt_t s, int k);
        rt_t r;
        logic [ROOT_SQ_W-1:0] bit_sq, lin, c_sq, c_sq3;
        r      = s;
        bit_sq = ROOT_SQ_W'(1) << (2 * k);
        lin    = ROOT_SQ_W'(s.mag) << (k + 1);
        c_sq   = s.mag_sq + lin + bit_sq;
        if (c_sq <= ROOT_SQ_W'(s.base.m2))
        begin
            r.mag    = s.mag | (ROOT_W'(1) << k);
            r.mag_sq = c_sq;
        end
        // largest v with 3*v^2 <= lim2
        lin   = ROOT_SQ_W'(s.vmax) << (k + 1);
        c_sq3 = s.vmax_sq3 + lin + (lin << 1) + bit_sq + (bit_sq << 1);
        if (c_sq3 <= ROOT_SQ_W'(s.base.lim2))
        begin
            r.vmax     = s.vmax | (ROOT_W'(1) << k);
            r.vmax_sq3 = c_sq3;
        end
        return r;
    endfunction

    logic [NS-1:0] v_reg, v_next, v_src;
    logic [NS:0]   rdy;
    rt_t           entry;
    rt_t           st_reg  [NS];
    rt_t           st_next [NS];

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int j = NS - 1; j >= 0; j--)
        begin
            rdy[j] = !v_reg[j] || rdy[j+1];
        end
    end

    assign v_src  = {v_reg[NS-2:0], in_valid};
    assign v_next = (v_src & rdy[NS-1:0]) | (v_reg & ~rdy[NS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        entry          = '0;
        entry.base     = in_data;
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        if (j == 0)
        begin : g_first
            assign st_next[j] = root_step(entry, NS - 1 - j);
        end
        else
        begin : g_rest
            assign st_next[j] = root_step(st_reg[j-1], NS - 1 - j);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (rdy[j]) st_reg[j] <= st_next[j];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = st_reg[NS-1];

endmodule

// ----- rtl/fvsd_scale.sv -----
// vector limiting by long division, inverse clarke and min-max centring
module fvsd_scale
    import fvsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rt_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output ph_t  out_data
);

    localparam int ND = AB_W + 1;
    localparam int NS = ND + 4;

    typedef struct packed {
        logic              fault;
        logic              limited;
        logic [BUS_W-1:0]  bus;
        logic              neg_a;
        logic              neg_b;
        logic [AB_W-1:0]   abs_a;
        logic [AB_W-1:0]   abs_b;
        logic [ROOT_W-1:0] mag;
        logic [PROD_W-1:0] rem_a;
        logic [PROD_W-1:0] rem_b;
        logic [AB_W-1:0]   q_a;
        logic [AB_W-1:0]   q_b;
    } dv_t;

    typedef struct packed {
        logic                   fault;
        logic                   limited;
        logic [BUS_W-1:0]       bus;
        logic signed [AB_W:0]   al;
        logic                   neg_b;
        logic [AB_W-1:0]        abs_b;
    } sl_t;

    typedef struct packed {
        logic                       fault;
        logic                       limited;
        logic [BUS_W-1:0]           bus;
        logic signed [AB_W:0]       al;
        logic                       neg_b;
        logic [AB_W+K3_W-1:0]       prod_b;
    } sp_t;

    typedef struct packed {
        logic                  fault;
        logic                  limited;
        logic [BUS_W-1:0]      bus;
        logic signed [W_W-1:0] w0;
        logic signed [W_W-1:0] w1;
        logic signed [W_W-1:0] w2;
    } ws_t;

    function automatic dv_t div_step(dv_t s, int k);
        dv_t r;
        logic [PROD_W-1:0] dsh;
        r   = s;
        dsh = PROD_W'(s.mag) << k;
        if (s.rem_a >= dsh)
        begin
            r.rem_a = s.rem_a - dsh;
            r.q_a   = s.q_a | (AB_W'(1) << k);
        end
        if (s.rem_b >= dsh)
        begin
            r.rem_b = s.rem_b - dsh;
            r.q_b   = s.q_b | (AB_W'(1) << k);
        end
        return r;
    endfunction

    logic [NS-1:0] v_reg, v_next, v_src;
    logic [NS:0]   rdy;

    dv_t dv_reg  [ND];
    dv_t dv_next [ND];
    sl_t sl_reg, sl_next;
    sp_t sp_reg, sp_next;
    ws_t ws_reg, ws_next;
    ph_t ph_reg, ph_next;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int j = NS - 1; j >= 0; j--)
        begin
            rdy[j] = !v_reg[j] || rdy[j+1];
        end
    end

    assign v_src  = {v_reg[NS-2:0], in_valid};
    assign v_next = (v_src & rdy[NS-1:0]) | (v_reg & ~rdy[NS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // |alpha|*vmax and |beta|*vmax, later divided by the magnitude
    always_comb
    begin
        dv_next[0].fault   = in_data.base.fault;
        dv_next[0].limited = in_data.base.limited;
        dv_next[0].bus     = in_data.base.bus;
        dv_next[0].neg_a   = in_data.base.neg_a;
        dv_next[0].neg_b   = in_data.base.neg_b;
        dv_next[0].abs_a   = in_data.base.abs_a;
        dv_next[0].abs_b   = in_data.base.abs_b;
        dv_next[0].mag     = in_data.mag;
        dv_next[0].rem_a   = PROD_W'(in_data.base.abs_a) * PROD_W'(in_data.vmax);
        dv_next[0].rem_b   = PROD_W'(in_data.base.abs_b) * PROD_W'(in_data.vmax);
        dv_next[0].q_a     = '0;
        dv_next[0].q_b     = '0;
    end

    for (genvar j = 1; j < ND; j++)
    begin : g_div
        assign dv_next[j] = div_step(dv_reg[j-1], ND - 1 - j);
    end

    // limited vector replaces the rotated one, truncated toward zero
    always_comb
    begin
        logic [AB_W-1:0] a_sel;
        a_sel = dv_reg[ND-1].limited ? dv_reg[ND-1].q_a : dv_reg[ND-1].abs_a;
        sl_next.fault   = dv_reg[ND-1].fault;
        sl_next.limited = dv_reg[ND-1].limited;
        sl_next.bus     = dv_reg[ND-1].bus;
        sl_next.al      = dv_reg[ND-1].neg_a ? -$signed({1'b0, a_sel})
                                             : $signed({1'b0, a_sel});
        sl_next.neg_b   = dv_reg[ND-1].neg_b;
        sl_next.abs_b   = dv_reg[ND-1].limited ? dv_reg[ND-1].q_b : dv_reg[ND-1].abs_b;
    end

    always_comb
    begin
        sp_next.fault   = sl_reg.fault;
        sp_next.limited = sl_reg.limited;
        sp_next.bus     = sl_reg.bus;
        sp_next.al      = sl_reg.al;
        sp_next.neg_b   = sl_reg.neg_b;
        sp_next.prod_b  = (AB_W+K3_W)'(sl_reg.abs_b) * (AB_W+K3_W)'(HALF_SQRT3);
    end

    // sqrt(3)*beta rounded half away from zero, then the three phases
    always_comb
    begin
        logic [AB_W+K3_W-1:0] rnd;
        logic [W_W-2:0]       s3_mag;
        logic signed [W_W-1:0] s3b, al_w;
        rnd    = sp_reg.prod_b + ((AB_W+K3_W)'(1) << (S3_SHIFT - 1));
        s3_mag = rnd[S3_SHIFT +: (W_W-1)];
        s3b    = sp_reg.neg_b ? -$signed({1'b0, s3_mag}) : $signed({1'b0, s3_mag});
        al_w   = W_W'(sp_reg.al);
        ws_next.fault   = sp_reg.fault;
        ws_next.limited = sp_reg.limited;
        ws_next.bus     = sp_reg.bus;
        ws_next.w0      = al_w + al_w;
        ws_next.w1      = s3b - al_w;
        ws_next.w2      = -al_w - s3b;
    end

    always_comb
    begin
        logic signed [W_W-1:0] mx, mn;
        mx = ws_reg.w0;
        mn = ws_reg.w0;
        if (ws_reg.w1 > mx) mx = ws_reg.w1;
        if (ws_reg.w1 < mn) mn = ws_reg.w1;
        if (ws_reg.w2 > mx) mx = ws_reg.w2;
        if (ws_reg.w2 < mn) mn = ws_reg.w2;
        ph_next.fault   = ws_reg.fault;
        ph_next.limited = ws_reg.limited;
        ph_next.bus     = ws_reg.bus;
        ph_next.u_a = (U_W'(ws_reg.w0) <<< 1) - U_W'(mx) - U_W'(mn);
        ph_next.u_b = (U_W'(ws_reg.w1) <<< 1) - U_W'(mx) - U_W'(mn);
        ph_next.u_c = (U_W'(ws_reg.w2) <<< 1) - U_W'(mx) - U_W'(mn);
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ND; j++)
        begin
            if (rdy[j]) dv_reg[j] <= dv_next[j];
        end
        if (rdy[ND])   sl_reg <= sl_next;
        if (rdy[ND+1]) sp_reg <= sp_next;
        if (rdy[ND+2]) ws_reg <= ws_next;
        if (rdy[ND+3]) ph_reg <= ph_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = ph_reg;

endmodule

// ----- rtl/fvsd_duty.sv -----
// division by the bus voltage, half offset and clamp into duty cycles
module fvsd_duty
    import fvsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ph_t                     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0][DUTY_W-1:0]  duty,
    output logic                    was_limited,
    output logic                    bus_fault
);

    localparam int ND = QD_W + 1;
    localparam int NS = ND + 1;

    typedef struct packed {
        logic                     fault;
        logic                     limited;
        logic [BUS_W:0]           den;
        logic [2:0]               neg;
        logic [2:0]               ovf;
        logic [2:0][NUM_W-1:0]    rem;
        logic [2:0][QD_W-1:0]     q;
    } dy_t;

    typedef struct packed {
        logic                    fault;
        logic                    limited;
        logic [2:0][DUTY_W-1:0]  duty;
    } out_t;

    function automatic dy_t div_step(dy_t s, int k);
        dy_t r;
        logic [NUM_W-1:0] dsh;
        r   = s;
        dsh = NUM_W'(s.den) << k;
        for (int p = 0; p < 3; p++)
        begin
            if (s.rem[p] >= dsh)
            begin
                r.rem[p] = s.rem[p] - dsh;
                r.q[p]   = s.q[p] | (QD_W'(1) << k);
            end
        end
        return r;
    endfunction

    logic [NS-1:0] v_reg, v_next, v_src;
    logic [NS:0]   rdy;

    dy_t  dy_reg  [ND];
    dy_t  dy_next [ND];
    out_t o_reg, o_next;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int j = NS - 1; j >= 0; j--)
        begin
            rdy[j] = !v_reg[j] || rdy[j+1];
        end
    end

    assign v_src  = {v_reg[NS-2:0], in_valid};
    assign v_next = (v_src & rdy[NS-1:0]) | (v_reg & ~rdy[NS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // rounded |u|*2^15/(bus*64) becomes floor((|u|*1024 + bus) / (2*bus))
    always_comb
    begin
        logic signed [U_W-1:0] u [3];
        logic [U_W-1:0]        ua;
        logic [NUM_W-1:0]      num;
        u[0] = in_data.u_a;
        u[1] = in_data.u_b;
        u[2] = in_data.u_c;
        dy_next[0].fault   = in_data.fault;
        dy_next[0].limited = in_data.limited;
        dy_next[0].den     = {in_data.bus, 1'b0};
        for (int p = 0; p < 3; p++)
        begin
            ua  = u[p][U_W-1] ? U_W'(-u[p]) : U_W'(u[p]);
            num = (NUM_W'(ua) << NUM_SHIFT) + NUM_W'(in_data.bus);
            dy_next[0].neg[p] = u[p][U_W-1];
            dy_next[0].ovf[p] = num >= (NUM_W'({in_data.bus, 1'b0}) << QD_W);
            dy_next[0].rem[p] = num;
            dy_next[0].q[p]   = '0;
        end
    end

    for (genvar j = 1; j < ND; j++)
    begin : g_div
        assign dy_next[j] = div_step(dy_reg[j-1], ND - 1 - j);
    end

    always_comb
    begin
        logic big;
        o_next.fault   = dy_reg[ND-1].fault;
        o_next.limited = dy_reg[ND-1].limited;
        for (int p = 0; p < 3; p++)
        begin
            big = dy_reg[ND-1].ovf[p] || (dy_reg[ND-1].q[p] >= QD_W'(HALF_DUTY));
            if (dy_reg[ND-1].fault)
            begin
                o_next.duty[p] = '0;
            end
            else if (dy_reg[ND-1].neg[p])
            begin
                o_next.duty[p] = big ? '0 : HALF_DUTY - DUTY_W'(dy_reg[ND-1].q[p]);
            end
            else
            begin
                o_next.duty[p] = big ? FULL_DUTY : HALF_DUTY + DUTY_W'(dy_reg[ND-1].q[p]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ND; j++)
        begin
            if (rdy[j]) dy_reg[j] <= dy_next[j];
        end
        if (rdy[ND]) o_reg <= o_next;
    end

    assign in_ready    = rdy[0];
    assign out_valid   = v_reg[NS-1];
    assign duty        = o_reg.duty;
    assign was_limited = o_reg.limited;
    assign bus_fault   = o_reg.fault;

endmodule

// ----- rtl/foc_voltage_to_svpwm_duty.sv -----
// top level: d/q voltage command to three space vector duty cycles
//
//  channel | handshake           | payload
//  in      | in_valid, in_ready  | volt_d, volt_q, angle_sine, angle_cosine, bus_voltage
//  out     | out_valid, out_ready| duty_phase_a/b/c, was_limited, bus_fault
//
// one transfer per cycle in each direction while out_ready is high
// depth is set by the two bit-per-stage square roots, run side by side in 21 stages,
// the 21 stage limiting division and the 17 stage division by the bus voltage
// reset clears only the stage valid bits
// a stage holds while it is full and the next one cannot take its transfer, so bubbles
// close up and a stall reaches the input only once every stage holds a transfer
module foc_voltage_to_svpwm_duty
    import fvsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VOLT_W-1:0] volt_d,
    input  logic signed [VOLT_W-1:0] volt_q,
    input  logic signed [TRIG_W-1:0] angle_sine,
    input  logic signed [TRIG_W-1:0] angle_cosine,
    input  logic [BUS_W-1:0]         bus_voltage,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DUTY_W-1:0]        duty_phase_a,
    output logic [DUTY_W-1:0]        duty_phase_b,
    output logic [DUTY_W-1:0]        duty_phase_c,
    output logic                     was_limited,
    output logic                     bus_fault
);

    logic fr_valid, fr_ready, rt_valid, rt_ready, ph_valid, ph_ready;
    sq_t  fr_data;
    rt_t  rt_data;
    ph_t  ph_data;
    logic [2:0][DUTY_W-1:0] duty;

    fvsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .volt_d       (volt_d),
        .volt_q       (volt_q),
        .angle_sine   (angle_sine),
        .angle_cosine (angle_cosine),
        .bus_voltage  (bus_voltage),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .out_data     (fr_data)
    );

    fvsd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_data  (rt_data)
    );

    fvsd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_ready  (rt_ready),
        .in_data   (rt_data),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_data  (ph_data)
    );

    fvsd_duty u_duty (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (ph_valid),
        .in_ready    (ph_ready),
        .in_data     (ph_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duty        (duty),
        .was_limited (was_limited),
        .bus_fault   (bus_fault)
    );

    assign duty_phase_a = duty[0];
    assign duty_phase_b = duty[1];
    assign duty_phase_c = duty[2];

`ifndef SYNTH
    // input held back only when the whole pipeline is full and stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while pipeline has room");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_fault |-> duty_phase_a == '0 && duty_phase_b == '0
                                   && duty_phase_c == '0 && !was_limited)
        else $error("fault result with non-zero duty or limit flag");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_phase_a <= FULL_DUTY && duty_phase_b <= FULL_DUTY
                      && duty_phase_c <= FULL_DUTY)
        else $error("duty above full scale");
`endif

endmodule
